FILE: hdl/textured_wall_column_shader_top_assert.svh
// assertion macros for the textured wall column shader
`ifndef TEXTURED_WALL_COLUMN_SHADER_TOP_ASSERT_SVH
`define TEXTURED_WALL_COLUMN_SHADER_TOP_ASSERT_SVH

// same-cycle implication, sampled on clk, off during rst
`define TWS_ASSERT_HOLDS(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during rst
`define TWS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/tws_pkg.sv
// package: constants, payload types and codes of the wall column shader
package tws_pkg;

  localparam int SCREEN_HEIGHT = 512;
  localparam int SCREEN_WIDTH  = 1024;
  localparam int TEXTURE_SIZE  = 64;

  localparam int TEX_BITS    = $clog2(TEXTURE_SIZE);
  localparam int TEXEL_W     = 12;
  localparam int TEX_SEL_W   = 2;
  localparam int STORE_AW    = TEX_SEL_W + TEXEL_W;
  localparam int STORE_DEPTH = 2 ** STORE_AW;
  localparam int COLOR_W     = 32;
  localparam int ADDR_W      = 19;
  localparam int REGION_W    = 2;
  localparam int HEIGHT_W    = 24;
  localparam int NUM_W       = 25;
  localparam int NT_W        = NUM_W + TEX_BITS;
  localparam int CMP_W       = 26;
  localparam int FRAC_W      = 16;
  localparam int HALF        = SCREEN_HEIGHT * 256;
  localparam int CFG_IDX_W   = 1;

  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_SHADE = 1'b1;

  localparam logic [REGION_W-1:0] REGION_CEILING = 2'd0;
  localparam logic [REGION_W-1:0] REGION_WALL    = 2'd1;
  localparam logic [REGION_W-1:0] REGION_FLOOR   = 2'd2;

  localparam logic [TEX_SEL_W-1:0] TEX_NORTH = 2'd0;
  localparam logic [TEX_SEL_W-1:0] TEX_SOUTH = 2'd1;
  localparam logic [TEX_SEL_W-1:0] TEX_WEST  = 2'd2;
  localparam logic [TEX_SEL_W-1:0] TEX_EAST  = 2'd3;

  localparam logic [15:0] ANGLE_QUARTER = 16'd16384;
  localparam logic [15:0] ANGLE_HALF    = 16'd32768;
  localparam logic [15:0] ANGLE_3QUART  = 16'd49152;

  localparam logic [CFG_IDX_W-1:0] REG_CEILING_COLOR = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_FLOOR_COLOR   = 1'b1;

  typedef struct packed {
    logic                 action;
    logic [TEX_SEL_W-1:0] texture_pick;
    logic [TEXEL_W-1:0]   texel_index;
    logic [COLOR_W-1:0]   texel_color;
    logic [9:0]           column;
    logic [8:0]           row;
    logic [HEIGHT_W-1:0]  wall_span;
    logic [FRAC_W-1:0]    hit_fraction;
    logic                 hit_side;
    logic [15:0]          ray_angle;
    logic [11:0]          wall_row_count;
  } item_t;

  typedef struct packed {
    logic [ADDR_W-1:0]   pixel_address;
    logic [COLOR_W-1:0]  pixel_color;
    logic [REGION_W-1:0] region;
  } pixel_t;

  typedef struct packed {
    logic                 action;
    logic [TEX_SEL_W-1:0] tex;
    logic [TEXEL_W-1:0]   load_index;
    logic [COLOR_W-1:0]   texel_color;
    logic [TEX_BITS-1:0]  tx;
    logic [ADDR_W-1:0]    pixel_address;
    logic [REGION_W-1:0]  region;
    logic                 sat;
  } meta_t;

  typedef struct packed {
    meta_t               meta;
    logic [NT_W-1:0]     rem;
    logic [NUM_W-1:0]    den;
    logic [TEX_BITS-1:0] q;
  } div_t;

endpackage

FILE: hdl/tws_tex_ram.sv
// texture store: one write port, one registered read port
module tws_tex_ram #(
  parameter int DEPTH = 16384,
  parameter int DW    = 32,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: hdl/tws_front.sv
// input stage: region, texture pick, texel column, row numerator and address
module tws_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           adv,
  input  logic           item_valid,
  input  tws_pkg::item_t item,
  output logic           valid,
  output tws_pkg::div_t  stage
);
  import tws_pkg::*;

  logic                 on_screen;
  logic                 is_ceiling;
  logic                 is_wall;
  logic [HEIGHT_W-1:0]  over;
  logic [NUM_W-1:0]     num;
  logic [NUM_W-1:0]     den;
  logic [FRAC_W+TEX_BITS-1:0] tx_prod;
  logic [31:0]          addr_full;
  logic [TEX_SEL_W-1:0] tex;
  div_t                 stage_next;

  always_comb begin
    on_screen  = (32'(item.row) < 32'(SCREEN_HEIGHT)) && (32'(item.column) < 32'(SCREEN_WIDTH));
    is_ceiling = (((CMP_W'(item.row) + CMP_W'(1)) << 9) + CMP_W'(item.wall_span))
                 <= CMP_W'(HALF);
    is_wall    = ((CMP_W'(item.row) + CMP_W'(2)) << 9)
                 <= (CMP_W'(HALF) + CMP_W'(item.wall_span));
    over       = (item.wall_span > HEIGHT_W'(HALF)) ?
                 (item.wall_span - HEIGHT_W'(HALF)) : '0;
    num        = NUM_W'(over) + (NUM_W'(item.wall_row_count) << 9);
    den        = NUM_W'(item.wall_span) << 1;
    tx_prod    = (FRAC_W+TEX_BITS)'(item.hit_fraction) * (FRAC_W+TEX_BITS)'(TEXTURE_SIZE);
    addr_full  = 32'(item.row) * 32'(SCREEN_WIDTH) + 32'(item.column);

    if (item.hit_side == 1'b0) begin
      tex = (item.ray_angle <= ANGLE_HALF) ? TEX_NORTH : TEX_SOUTH;
    end else begin
      tex = (item.ray_angle inside {[ANGLE_QUARTER:ANGLE_3QUART]}) ? TEX_WEST : TEX_EAST;
    end

    stage_next.meta.action        = item.action;
    stage_next.meta.tex           = (item.action == ACT_LOAD) ? item.texture_pick : tex;
    stage_next.meta.load_index    = item.texel_index;
    stage_next.meta.texel_color   = item.texel_color;
    stage_next.meta.tx            = tx_prod[FRAC_W +: TEX_BITS];
    stage_next.meta.pixel_address = addr_full[ADDR_W-1:0];
    stage_next.meta.region        = is_ceiling ? REGION_CEILING :
                                    (is_wall ? REGION_WALL : REGION_FLOOR);
    stage_next.meta.sat           = (num >= den);
    stage_next.rem                = NT_W'(num) * NT_W'(TEXTURE_SIZE);
    stage_next.den                = den;
    stage_next.q                  = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (adv) begin
      valid <= item_valid && ((item.action == ACT_LOAD) || on_screen);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      stage <= stage_next;
    end
  end

endmodule

FILE: hdl/tws_div.sv
// texel row divider: restoring, one quotient bit per stage
module tws_div (
  input  logic          clk,
  input  logic          rst,
  input  logic          adv,
  input  logic          in_valid,
  input  tws_pkg::div_t in_stage,
  output logic          out_valid,
  output tws_pkg::div_t out_stage
);
  import tws_pkg::*;

  logic [TEX_BITS-1:0] valid;
  div_t                st [TEX_BITS];

  for (genvar i = 0; i < TEX_BITS; i++) begin : g_step
    localparam int K = TEX_BITS - 1 - i;
    logic            src_valid;
    div_t            src;
    div_t            nxt;
    logic [NT_W-1:0] dsh;

    if (i == 0) begin : g_first
      assign src_valid = in_valid;
      assign src       = in_stage;
    end else begin : g_rest
      assign src_valid = valid[i-1];
      assign src       = st[i-1];
    end

    always_comb begin
      dsh = NT_W'(src.den) << K;
      nxt = src;
      if (src.rem >= dsh) begin
        nxt.rem  = src.rem - dsh;
        nxt.q[K] = 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        valid[i] <= 1'b0;
      end else if (adv) begin
        valid[i] <= src_valid;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        st[i] <= nxt;
      end
    end
  end

  assign out_valid = valid[TEX_BITS-1];
  assign out_stage = st[TEX_BITS-1];

endmodule

FILE: hdl/textured_wall_column_shader_top.sv
// top level of the textured wall column shader
//
//  channel  | handshake              | payload
//  item     | item_valid/item_stall  | item   (load texel or shade pixel)
//  pixel    | pixel_valid/pixel_stall| pixel  (address, color, region)
//  cfg      | cfg_valid/cfg_ready    | cfg_index, cfg_data
//
// one item per cycle while item_stall is low; a pixel passes the front stage, the divider steps,
// the store read stage and the pixel register; the texel row divider gives one quotient bit per stage
// loads write the texture store in order with shade reads at the same stage
// rst is synchronous; the texture store has no reset and no clearing pass
// a stalled pixel freezes the whole pipeline and stalls the item channel
module textured_wall_column_shader_top (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              item_valid,
  output logic                              item_stall,
  input  tws_pkg::item_t                    item,
  output logic                              pixel_valid,
  input  logic                              pixel_stall,
  output tws_pkg::pixel_t                   pixel,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [tws_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [tws_pkg::COLOR_W-1:0]       cfg_data
);
  import tws_pkg::*;

  logic                 adv;
  logic                 f_valid;
  div_t                 f_stage;
  logic                 d_valid;
  div_t                 d_stage;
  logic [TEX_BITS-1:0]  ty;
  logic [31:0]          idx_full;
  logic                 mem_we;
  logic                 mem_re;
  logic [STORE_AW-1:0]  mem_waddr;
  logic [STORE_AW-1:0]  mem_raddr;
  logic [COLOR_W-1:0]   mem_rdata;
  logic                 m_valid;
  logic [ADDR_W-1:0]    m_address;
  logic [REGION_W-1:0]  m_region;
  logic [COLOR_W-1:0]   ceiling_color;
  logic [COLOR_W-1:0]   floor_color;
  pixel_t               pixel_next;

  assign adv        = !pixel_valid || !pixel_stall;
  assign item_stall = !adv;
  assign cfg_ready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      ceiling_color <= '0;
      floor_color   <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_CEILING_COLOR: ceiling_color <= cfg_data;
        REG_FLOOR_COLOR:   floor_color   <= cfg_data;
        default: ;
      endcase
    end
  end

  tws_front u_front (
    .clk        (clk),
    .rst        (rst),
    .adv        (adv),
    .item_valid (item_valid),
    .item       (item),
    .valid      (f_valid),
    .stage      (f_stage)
  );

  tws_div u_div (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (f_valid),
    .in_stage  (f_stage),
    .out_valid (d_valid),
    .out_stage (d_stage)
  );

  // texel address and store access
  always_comb begin
    ty        = d_stage.meta.sat ? TEX_BITS'(TEXTURE_SIZE - 1) : d_stage.q;
    idx_full  = 32'(ty) * 32'(TEXTURE_SIZE) + 32'(d_stage.meta.tx);
    mem_we    = adv && d_valid && (d_stage.meta.action == ACT_LOAD);
    mem_re    = adv && d_valid && (d_stage.meta.action == ACT_SHADE)
                && (d_stage.meta.region == REGION_WALL);
    mem_waddr = {d_stage.meta.tex, d_stage.meta.load_index};
    mem_raddr = {d_stage.meta.tex, idx_full[TEXEL_W-1:0]};
  end

  tws_tex_ram #(
    .DEPTH (STORE_DEPTH),
    .DW    (COLOR_W),
    .AW    (STORE_AW)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (d_stage.meta.texel_color),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else if (adv) begin
      m_valid <= d_valid && (d_stage.meta.action == ACT_SHADE);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_address <= d_stage.meta.pixel_address;
      m_region  <= d_stage.meta.region;
    end
  end

  always_comb begin
    pixel_next.pixel_address = m_address;
    pixel_next.region        = m_region;
    case (m_region)
      REGION_CEILING: pixel_next.pixel_color = ceiling_color;
      REGION_WALL:    pixel_next.pixel_color = mem_rdata;
      default:        pixel_next.pixel_color = floor_color;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_valid <= 1'b0;
    end else if (adv) begin
      pixel_valid <= m_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pixel <= pixel_next;
    end
  end

endmodule

FILE: hdl/tws_checker.sv
// port-level checker for the textured wall column shader, bound to the top level
`include "textured_wall_column_shader_top_assert.svh"

module tws_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          item_valid,
  input logic                          item_stall,
  input tws_pkg::item_t                item,
  input logic                          pixel_valid,
  input logic                          pixel_stall,
  input tws_pkg::pixel_t               pixel,
  input logic                          cfg_valid,
  input logic                          cfg_ready,
  input logic [tws_pkg::CFG_IDX_W-1:0] cfg_index,
  input logic [tws_pkg::COLOR_W-1:0]   cfg_data
);
  import tws_pkg::*;

  logic                item_xfer;
  logic                pixel_xfer;
  logic [7:0]          pending;
  logic [COLOR_W-1:0]  ceiling_shadow;
  logic [COLOR_W-1:0]  floor_shadow;

  assign item_xfer  = item_valid && !item_stall && (item.action == ACT_SHADE);
  assign pixel_xfer = pixel_valid && !pixel_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else if (item_xfer && !pixel_xfer && (pending != 8'hff)) begin
      pending <= pending + 8'd1;
    end else if (pixel_xfer && !item_xfer && (pending != 8'd0)) begin
      pending <= pending - 8'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ceiling_shadow <= '0;
      floor_shadow   <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_CEILING_COLOR: ceiling_shadow <= cfg_data;
        REG_FLOOR_COLOR:   floor_shadow   <= cfg_data;
        default: ;
      endcase
    end
  end

  `TWS_ASSERT_NEXT(a_pixel_hold, pixel_valid && pixel_stall, pixel_valid && $stable(pixel), "stalled pixel changed")
  `TWS_ASSERT_HOLDS(a_no_extra_pixel, pixel_xfer, pending != 8'd0, "pixel without a shade transfer")
  `TWS_ASSERT_HOLDS(a_ceiling_color, pixel_valid && (pixel.region == REGION_CEILING), pixel.pixel_color == ceiling_shadow, "ceiling pixel color mismatch")
  `TWS_ASSERT_HOLDS(a_floor_color, pixel_valid && (pixel.region == REGION_FLOOR), pixel.pixel_color == floor_shadow, "floor pixel color mismatch")

endmodule

bind textured_wall_column_shader_top tws_checker u_tws_checker (.*);

FILE: verif/tb.sv
// testbench for the textured wall column shader: texel loads, shaded pixels, color registers
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import tws_pkg::*;

  localparam int FULL_H = SCREEN_HEIGHT * 256;
  localparam int SLOTS  = 4096;
  localparam int LINGER = 20;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 item_valid = 1'b0;
  logic                 item_stall;
  item_t                item = '0;
  logic                 pixel_valid;
  logic                 pixel_stall = 1'b0;
  pixel_t               pixel;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [COLOR_W-1:0]   cfg_data = '0;

  item_t              pending_items[$];
  pixel_t             pixel_expected[$];
  logic [COLOR_W-1:0] texel_mirror [STORE_DEPTH];
  bit                 loaded [STORE_DEPTH];
  logic [COLOR_W-1:0] ceiling_shadow = '0;
  logic [COLOR_W-1:0] floor_shadow = '0;
  int                 items_queued = 0;
  int                 items_taken = 0;
  int                 cfg_writes = 0;
  int                 mismatches = 0;
  int                 loads_seen = 0;
  int                 region_seen [3] = '{0, 0, 0};
  bit                 item_taken = 1'b0;
  bit                 calm = 1'b0;

  textured_wall_column_shader_top uut (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item_valid),
    .item_stall  (item_stall),
    .item        (item),
    .pixel_valid (pixel_valid),
    .pixel_stall (pixel_stall),
    .pixel       (pixel),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  always #6 clk = ~clk;

  function automatic logic [REGION_W-1:0] row_region(input logic [8:0] r,
                                                     input logic [HEIGHT_W-1:0] h);
    longint unsigned rr;
    longint unsigned hh;
    rr = r;
    hh = h;
    if ((rr + 1) * 512 + hh <= FULL_H) return REGION_CEILING;
    if ((rr + 2) * 512 <= FULL_H + hh) return REGION_WALL;
    return REGION_FLOOR;
  endfunction

  // store word that a wall pixel reads
  function automatic int texel_slot(input item_t it);
    longint unsigned h;
    longint unsigned d;
    longint unsigned cnt;
    longint unsigned frac;
    longint unsigned ty;
    longint unsigned tx;
    logic [TEX_SEL_W-1:0] tex;
    h = it.wall_span;
    cnt = it.wall_row_count;
    frac = it.hit_fraction;
    d = (h > FULL_H) ? h - FULL_H : 0;
    if (h == 0) begin
      ty = TEXTURE_SIZE - 1;
    end else begin
      ty = ((d + cnt * 512) * TEXTURE_SIZE) / (2 * h);
    end
    if (ty > TEXTURE_SIZE - 1) ty = TEXTURE_SIZE - 1;
    tx = (frac * TEXTURE_SIZE) >> 16;
    if (it.hit_side == 1'b0) begin
      tex = (it.ray_angle <= ANGLE_HALF) ? TEX_NORTH : TEX_SOUTH;
    end else begin
      tex = (it.ray_angle >= ANGLE_QUARTER && it.ray_angle <= ANGLE_3QUART) ? TEX_WEST : TEX_EAST;
    end
    return int'(tex) * SLOTS + int'((ty * TEXTURE_SIZE + tx) % SLOTS);
  endfunction

  function automatic pixel_t shade_pixel(input item_t it);
    pixel_t p;
    p.pixel_address = ADDR_W'(int'(it.row) * SCREEN_WIDTH + int'(it.column));
    p.region = row_region(it.row, it.wall_span);
    case (p.region)
      REGION_CEILING: p.pixel_color = ceiling_shadow;
      REGION_WALL:    p.pixel_color = texel_mirror[texel_slot(it)];
      default:        p.pixel_color = floor_shadow;
    endcase
    return p;
  endfunction

  function automatic item_t random_item();
    item_t it;
    it.action = 1'($urandom);
    it.texture_pick = TEX_SEL_W'($urandom);
    it.texel_index = TEXEL_W'($urandom);
    it.texel_color = $urandom;
    it.column = 10'($urandom);
    it.row = 9'($urandom);
    it.wall_span = HEIGHT_W'($urandom);
    it.hit_fraction = FRAC_W'($urandom);
    it.hit_side = 1'($urandom);
    it.ray_angle = 16'($urandom);
    it.wall_row_count = 12'($urandom);
    return it;
  endfunction

  function automatic item_t load_item(input logic [TEX_SEL_W-1:0] pick,
                                      input logic [TEXEL_W-1:0] idx,
                                      input logic [COLOR_W-1:0] color);
    item_t it;
    it = random_item();
    it.action = ACT_LOAD;
    it.texture_pick = pick;
    it.texel_index = idx;
    it.texel_color = color;
    return it;
  endfunction

  function automatic item_t shade_item(input int col, input int r, input int h, input int frac,
                                       input bit side, input int angle, input int count);
    item_t it;
    it = random_item();
    it.action = ACT_SHADE;
    it.column = 10'(col);
    it.row = 9'(r);
    it.wall_span = HEIGHT_W'(h);
    it.hit_fraction = FRAC_W'(frac);
    it.hit_side = side;
    it.ray_angle = 16'(angle);
    it.wall_row_count = 12'(count);
    return it;
  endfunction

  function automatic int random_height();
    case ($urandom_range(3))
      0:       return $urandom_range(4096);
      1:       return $urandom_range(FULL_H, 4096);
      2:       return $urandom_range(4 * FULL_H, FULL_H);
      default: return $urandom_range(24'hFFFFFF);
    endcase
  endfunction

  // a wall pixel never reads a texel that was not loaded first
  task automatic push_item(input item_t it);
    int slot;
    if (it.action == ACT_LOAD) begin
      loaded[int'(it.texture_pick) * SLOTS + int'(it.texel_index)] = 1'b1;
    end else if (row_region(it.row, it.wall_span) == REGION_WALL) begin
      slot = texel_slot(it);
      if (!loaded[slot]) begin
        push_item(load_item(TEX_SEL_W'(slot / SLOTS), TEXEL_W'(slot % SLOTS), $urandom));
      end
    end
    pending_items.push_back(it);
    items_queued++;
  endtask

  // run of rows down one screen column, wall rows counted from the wall top
  task automatic column_strip();
    int col;
    int h;
    int frac;
    int angle;
    int top;
    int bottom;
    int start;
    int len;
    bit side;
    h = random_height();
    col = $urandom_range(SCREEN_WIDTH - 1);
    frac = $urandom_range(16'hFFFF);
    angle = $urandom_range(16'hFFFF);
    side = 1'($urandom);
    top = (h >= FULL_H) ? 0 : (FULL_H - h) / 512;
    bottom = (FULL_H + h) / 512 - 1;
    if (bottom > SCREEN_HEIGHT - 1) bottom = SCREEN_HEIGHT - 1;
    case ($urandom_range(2))
      0:       start = top - $urandom_range(4);
      1:       start = bottom - $urandom_range(6);
      default: start = $urandom_range(SCREEN_HEIGHT - 1);
    endcase
    if (start < 0) start = 0;
    if (start > SCREEN_HEIGHT - 1) start = SCREEN_HEIGHT - 1;
    len = $urandom_range(16, 4);
    for (int r = start; r < start + len && r < SCREEN_HEIGHT; r++) begin
      push_item(shade_item(col, r, h, frac, side, angle, (r >= top) ? r - top : 0));
    end
  endtask

  task automatic random_phase(input int n);
    int first;
    item_t it;
    first = items_queued;
    while (items_queued - first < n) begin
      case ($urandom_range(9))
        0, 1: push_item(load_item(TEX_SEL_W'($urandom), TEXEL_W'($urandom), $urandom));
        2: begin
          it = random_item();
          it.action = ACT_SHADE;
          push_item(it);
        end
        default: column_strip();
      endcase
    end
  endtask

  task automatic wait_idle();
    while (items_taken != items_queued || pixel_expected.size() != 0) @(negedge clk);
    repeat (LINGER) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COLOR_W-1:0] val);
    int writes_at_start;
    writes_at_start = cfg_writes;
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(negedge clk); while (cfg_writes == writes_at_start);
    cfg_valid <= 1'b0;
  endtask

  always @(negedge clk) begin : driver
    if (rst) begin
      item_valid <= 1'b0;
    end else if (!item_valid || item_taken) begin
      if (pending_items.size() != 0 && (calm || $urandom_range(99) >= 18)) begin
        item <= pending_items.pop_front();
        item_valid <= 1'b1;
      end else begin
        item_valid <= 1'b0;
      end
    end
    pixel_stall <= !rst && !calm && ($urandom_range(99) < 18);
  end

  always @(posedge clk) begin : monitor
    pixel_t want;
    if (rst) begin
      item_taken <= 1'b0;
    end else begin
      item_taken <= item_valid && !item_stall;
      if (pixel_valid && !pixel_stall) begin
        if (pixel_expected.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("pixel with none expected: %p", pixel);
        end else begin
          want = pixel_expected.pop_front();
          if (want.pixel_address !== pixel.pixel_address ||
              want.pixel_color !== pixel.pixel_color || want.region !== pixel.region) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("pixel mismatch: address %h/%h color %h/%h region %0d/%0d (exp/got)",
                       want.pixel_address, pixel.pixel_address, want.pixel_color,
                       pixel.pixel_color, want.region, pixel.region);
            end
          end else begin
            region_seen[pixel.region]++;
          end
        end
      end
      if (item_valid && !item_stall) begin
        items_taken <= items_taken + 1;
        if (item.action == ACT_LOAD) begin
          texel_mirror[int'(item.texture_pick) * SLOTS + int'(item.texel_index)] = item.texel_color;
          loads_seen++;
        end else begin
          pixel_expected.push_back(shade_pixel(item));
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_CEILING_COLOR: ceiling_shadow = cfg_data;
          REG_FLOOR_COLOR:   floor_shadow = cfg_data;
          default: ;
        endcase
        cfg_writes <= cfg_writes + 1;
      end
    end
  end

  initial begin
    repeat (8) @(negedge clk);
    rst <= 1'b0;

    write_reg(REG_CEILING_COLOR, '1);
    write_reg(REG_FLOOR_COLOR, '0);
    push_item(load_item(TEX_NORTH, 12'd0, 32'h0000_0000));
    push_item(load_item(TEX_SOUTH, 12'hFFF, 32'hFFFF_FFFF));
    push_item(load_item(TEX_WEST, 12'd0, 32'hA5A5_A5A5));
    push_item(load_item(TEX_EAST, 12'hFFF, 32'h5A5A_5A5A));
    // zero height
    push_item(shade_item(0, 0, 0, 0, 0, 0, 0));
    push_item(shade_item(1023, 511, 0, 'hFFFF, 1, 'hFFFF, 'hFFF));
    // tallest wall
    push_item(shade_item(0, 0, 'hFFFFFF, 0, 0, 0, 0));
    push_item(shade_item(1023, 511, 'hFFFFFF, 'hFFFF, 1, 'hFFFF, 'hFFF));
    // three-row wall: band edges and texture angle edges
    push_item(shade_item(5, 253, 1024, 'h8000, 0, ANGLE_HALF, 0));
    push_item(shade_item(5, 254, 1024, 'h8000, 0, ANGLE_HALF, 0));
    push_item(shade_item(5, 255, 1024, 'h8000, 0, ANGLE_HALF + 1, 1));
    push_item(shade_item(5, 256, 1024, 'h8000, 1, ANGLE_QUARTER - 1, 2));
    push_item(shade_item(5, 256, 1024, 'h8000, 1, ANGLE_QUARTER, 2));
    push_item(shade_item(5, 256, 1024, 'h8000, 1, ANGLE_3QUART, 2));
    push_item(shade_item(5, 256, 1024, 'h8000, 1, ANGLE_3QUART + 1, 3));
    push_item(shade_item(5, 257, 1024, 'h8000, 1, 0, 3));
    // texel row saturates
    push_item(shade_item(700, 255, 1024, 'h4321, 0, 100, 'hFFF));
    // wall at screen height and one step over
    push_item(shade_item(300, 0, FULL_H, 'hFFFF, 0, 'hFFFF, 0));
    push_item(shade_item(300, 511, FULL_H + 1, 'h1, 1, 'h8000, 511));
    wait_idle();

    write_reg(REG_CEILING_COLOR, '0);
    write_reg(REG_FLOOR_COLOR, '1);
    random_phase(130);
    wait_idle();

    write_reg(REG_CEILING_COLOR, $urandom);
    write_reg(REG_FLOOR_COLOR, $urandom);
    calm = 1'b1;
    random_phase(130);
    wait_idle();
    calm = 1'b0;

    write_reg(REG_CEILING_COLOR, $urandom);
    write_reg(REG_FLOOR_COLOR, $urandom);
    random_phase(70);
    wait_idle();
    random_phase(70);
    wait_idle();

    $display("covered %0d texel loads and %0d pixels: %0d ceiling, %0d wall, %0d floor",
             loads_seen, region_seen[0] + region_seen[1] + region_seen[2],
             region_seen[0], region_seen[1], region_seen[2]);
    $display("%0d color register writes across four settings, %0d mismatches",
             cfg_writes, mismatches);
    if (mismatches == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

  initial begin
    #4_800_000;
    $display("tb failed");
    $finish;
  end

endmodule
